@@ src/rmspr_pkg.sv @@
// Shared constants, register codes and payload types for the RMSProp update block.
package rmspr_pkg;

   // field and datapath widths
   localparam int DATA_W = 32;
   localparam int FRAC   = 24;
   localparam int SQ_W   = 31;
   localparam int CFG_W  = 25;
   localparam int IDX_W  = 8;
   localparam int CSR_W  = 32;
   localparam int ROOT_W = 28;            // root of a 56-bit radicand
   localparam int RAD_W  = 2 * ROOT_W;    // (den + eps) << FRAC
   localparam int REM_W  = ROOT_W + 2;    // square root partial remainder
   localparam int NUM_W  = 57;            // lr * |g|
   localparam int DIVN_W = NUM_W + 1;     // dividend with rounding term

   localparam logic [CFG_W-1:0] ONE  = CFG_W'(1) << FRAC;
   localparam logic [63:0]      HALF = 64'd1 << (FRAC - 1);

   // register indexes
   localparam logic [IDX_W-1:0] CSR_LR     = 8'd0;
   localparam logic [IDX_W-1:0] CSR_DECAY  = 8'd1;
   localparam logic [IDX_W-1:0] CSR_EPS    = 8'd2;
   localparam logic [IDX_W-1:0] CSR_CENTER = 8'd3;

   // register reset values
   localparam logic [CFG_W-1:0] LR_RESET    = 25'd167772;
   localparam logic [CFG_W-1:0] DECAY_RESET = 25'd15099494;
   localparam logic [CFG_W-1:0] EPS_RESET   = 25'd1;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [CFG_W-1:0] lr;
      logic [CFG_W-1:0] decay;   // clamped to one
      logic [CFG_W-1:0] omd;     // one minus decay
      logic [CFG_W-1:0] eps;     // zero reads as one
      logic             centered;
   } cfg_type;

   // per-item values carried alongside the root and divide
   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic [SQ_W-1:0]          mean_sq;
      logic signed [DATA_W-1:0] mean_grad;
      logic                     last;
      logic                     gneg;
   } side_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_W-1:0] new_weight;
      logic [SQ_W-1:0]          mean_sq;
      logic signed [DATA_W-1:0] mean_grad;
      logic                     last;
   } res_type;

endpackage

@@ src/rmspr_if.sv @@
// Handshake channel interfaces for request, response and register writes.
interface rmspr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rmspr_pkg::DATA_W-1:0]     gradient;
   logic signed [rmspr_pkg::DATA_W-1:0]     weight;
   logic [rmspr_pkg::SQ_W-1:0]              mean_sq_in;
   logic signed [rmspr_pkg::DATA_W-1:0]     mean_grad_in;
   logic                                    last_in;

   modport source (output valid, gradient, weight, mean_sq_in, mean_grad_in, last_in,
                   input ready);
   modport sink   (input valid, gradient, weight, mean_sq_in, mean_grad_in, last_in,
                   output ready);
endinterface

interface rmspr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rmspr_pkg::DATA_W-1:0]     new_weight;
   logic [rmspr_pkg::SQ_W-1:0]              mean_sq_out;
   logic signed [rmspr_pkg::DATA_W-1:0]     mean_grad_out;
   logic                                    last_out;

   modport source (output valid, new_weight, mean_sq_out, mean_grad_out, last_out,
                   input ready);
   modport sink   (input valid, new_weight, mean_sq_out, mean_grad_out, last_out,
                   output ready);
endinterface

interface rmspr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rmspr_pkg::IDX_W-1:0]       index;
   logic [rmspr_pkg::CSR_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rmspr_front.sv @@
// Front pipeline: running averages, centered denominator and root radicand.
module rmspr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  rmspr_pkg::cfg_type                  cfg,
   input  logic                                in_valid,
   input  logic signed [rmspr_pkg::DATA_W-1:0] gradient,
   input  logic signed [rmspr_pkg::DATA_W-1:0] weight,
   input  logic [rmspr_pkg::SQ_W-1:0]          mean_sq_in,
   input  logic signed [rmspr_pkg::DATA_W-1:0] mean_grad_in,
   input  logic                                last_in,
   output logic                                out_valid,
   output logic [rmspr_pkg::RAD_W-1:0]         radicand,
   output logic [rmspr_pkg::NUM_W-1:0]         num,
   output rmspr_pkg::side_type                 side
);

   localparam int DW = rmspr_pkg::DATA_W;
   localparam int FR = rmspr_pkg::FRAC;

   logic [7:1] vld_ff;

   // stage 1: capture and magnitude
   logic signed [DW-1:0]          g1_ff, w1_ff, mg1_ff;
   logic [DW-1:0]                 gmag1_ff;
   logic [rmspr_pkg::SQ_W-1:0]    ms1_ff;
   logic                          last1_ff, gneg1_ff;

   // stage 2: products
   logic [63:0]                   g2raw2_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num2_ff;
   logic signed [57:0]            omdg2_ff, dmg2_ff;
   logic [55:0]                   dms2_ff;
   logic signed [DW-1:0]          w2_ff, mg2_ff;
   logic                          last2_ff, gneg2_ff;

   // stage 3: rounded square, mean gradient sum
   logic [38:0]                   g2s3_ff;
   logic signed [57:0]            macc3_ff;
   logic [55:0]                   dms3_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num3_ff;
   logic signed [DW-1:0]          w3_ff, mg3_ff;
   logic                          last3_ff, gneg3_ff;

   // stage 4: weighted square, new mean gradient
   logic [63:0]                   omdg4_ff;
   logic [55:0]                   dms4_ff;
   logic signed [DW-1:0]          mgn4_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num4_ff;
   logic signed [DW-1:0]          w4_ff, mg4_ff;
   logic                          last4_ff, gneg4_ff;

   // stage 5: mean square sum, squared mean gradient
   logic [63:0]                   acc5_ff, mg2raw5_ff;
   logic signed [DW-1:0]          mgn5_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num5_ff;
   logic signed [DW-1:0]          w5_ff, mg5_ff;
   logic                          last5_ff, gneg5_ff;

   // stage 6: rounding and saturation
   logic [rmspr_pkg::SQ_W-1:0]    msn6_ff;
   logic [38:0]                   mgsq6_ff;
   logic signed [DW-1:0]          mgn6_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num6_ff;
   logic signed [DW-1:0]          w6_ff, mg6_ff;
   logic                          last6_ff, gneg6_ff;

   // stage 7: denominator and radicand
   logic [rmspr_pkg::RAD_W-1:0]   rad7_ff;
   logic [rmspr_pkg::NUM_W-1:0]   num7_ff;
   rmspr_pkg::side_type           side7_ff;

   // combinational helpers
   logic [DW-1:0]                 gmag_in;
   logic [38:0]                   g2s_in;
   logic [57:0]                   mmag;
   logic [33:0]                   mrnd;
   logic signed [DW-1:0]          mgn_in;
   logic [DW-1:0]                 mgmag;
   logic [39:0]                   ms_sh;
   logic [rmspr_pkg::SQ_W-1:0]    msn_in;
   logic [rmspr_pkg::SQ_W-1:0]    den;
   logic [DW-1:0]                 den_eps;

   assign gmag_in = gradient[DW-1] ? DW'(-gradient) : DW'(gradient);
   assign g2s_in  = 39'((g2raw2_ff + rmspr_pkg::HALF) >> FR);

   // signed rounding of the mean gradient sum, then saturation
   always_comb begin
      mmag = macc3_ff[57] ? 58'(-macc3_ff) : 58'(macc3_ff);
      mrnd = 34'((mmag + 58'(rmspr_pkg::HALF)) >> FR);
      if (!macc3_ff[57]) begin
         mgn_in = (mrnd > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : DW'(mrnd);
      end else begin
         mgn_in = (mrnd > 34'h0_8000_0000) ? 32'sh8000_0000 : DW'(-mrnd);
      end
   end

   assign mgmag  = mgn4_ff[DW-1] ? DW'(-mgn4_ff) : DW'(mgn4_ff);
   assign ms_sh  = 40'((acc5_ff + rmspr_pkg::HALF) >> FR);
   assign msn_in = (ms_sh > 40'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(ms_sh);

   // centered denominator clamps at zero
   always_comb begin
      if (cfg.centered) begin
         den = (39'(msn6_ff) >= mgsq6_ff) ? 31'(39'(msn6_ff) - mgsq6_ff) : '0;
      end else begin
         den = msn6_ff;
      end
      den_eps = DW'(den) + DW'(cfg.eps);
   end

   // valid shift
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:1], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff    <= gradient;
         gmag1_ff <= gmag_in;
         gneg1_ff <= gradient[DW-1];
         w1_ff    <= weight;
         ms1_ff   <= mean_sq_in;
         mg1_ff   <= mean_grad_in;
         last1_ff <= last_in;

         g2raw2_ff <= 64'(gmag1_ff) * 64'(gmag1_ff);
         num2_ff   <= rmspr_pkg::NUM_W'(cfg.lr) * rmspr_pkg::NUM_W'(gmag1_ff);
         omdg2_ff  <= $signed({1'b0, cfg.omd}) * g1_ff;
         dmg2_ff   <= $signed({1'b0, cfg.decay}) * mg1_ff;
         dms2_ff   <= 56'(cfg.decay) * 56'(ms1_ff);
         w2_ff     <= w1_ff;
         mg2_ff    <= mg1_ff;
         last2_ff  <= last1_ff;
         gneg2_ff  <= gneg1_ff;

         g2s3_ff  <= g2s_in;
         macc3_ff <= omdg2_ff + dmg2_ff;
         dms3_ff  <= dms2_ff;
         num3_ff  <= num2_ff;
         w3_ff    <= w2_ff;
         mg3_ff   <= mg2_ff;
         last3_ff <= last2_ff;
         gneg3_ff <= gneg2_ff;

         omdg4_ff <= 64'(cfg.omd) * 64'(g2s3_ff);
         dms4_ff  <= dms3_ff;
         mgn4_ff  <= mgn_in;
         num4_ff  <= num3_ff;
         w4_ff    <= w3_ff;
         mg4_ff   <= mg3_ff;
         last4_ff <= last3_ff;
         gneg4_ff <= gneg3_ff;

         acc5_ff    <= omdg4_ff + 64'(dms4_ff);
         mg2raw5_ff <= 64'(mgmag) * 64'(mgmag);
         mgn5_ff    <= mgn4_ff;
         num5_ff    <= num4_ff;
         w5_ff      <= w4_ff;
         mg5_ff     <= mg4_ff;
         last5_ff   <= last4_ff;
         gneg5_ff   <= gneg4_ff;

         msn6_ff  <= msn_in;
         mgsq6_ff <= 39'((mg2raw5_ff + rmspr_pkg::HALF) >> FR);
         mgn6_ff  <= mgn5_ff;
         num6_ff  <= num5_ff;
         w6_ff    <= w5_ff;
         mg6_ff   <= mg5_ff;
         last6_ff <= last5_ff;
         gneg6_ff <= gneg5_ff;

         rad7_ff            <= {den_eps, {FR{1'b0}}};
         num7_ff            <= num6_ff;
         side7_ff.weight    <= w6_ff;
         side7_ff.mean_sq   <= msn6_ff;
         side7_ff.mean_grad <= cfg.centered ? mgn6_ff : mg6_ff;
         side7_ff.last      <= last6_ff;
         side7_ff.gneg      <= gneg6_ff;
      end
   end

   assign out_valid = vld_ff[7];
   assign radicand  = rad7_ff;
   assign num       = num7_ff;
   assign side      = side7_ff;

endmodule

@@ src/rmspr_sqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module rmspr_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rmspr_pkg::RAD_W-1:0]   radicand,
   input  logic [rmspr_pkg::NUM_W-1:0]   in_num,
   input  rmspr_pkg::side_type           in_side,
   output logic                          out_valid,
   output logic [rmspr_pkg::ROOT_W-1:0]  root,
   output logic [rmspr_pkg::NUM_W-1:0]   out_num,
   output rmspr_pkg::side_type           out_side
);

   localparam int N  = rmspr_pkg::ROOT_W;
   localparam int RW = rmspr_pkg::REM_W;

   logic                          vld_ff  [N];
   logic [rmspr_pkg::RAD_W-1:0]   rad_ff  [N];
   logic [RW-1:0]                 rem_ff  [N];
   logic [N-1:0]                  root_ff [N];
   logic [rmspr_pkg::NUM_W-1:0]   num_ff  [N];
   rmspr_pkg::side_type           side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                          pv;
      logic [rmspr_pkg::RAD_W-1:0]   prad;
      logic [RW-1:0]                 prem;
      logic [N-1:0]                  proot;
      logic [rmspr_pkg::NUM_W-1:0]   pnum;
      rmspr_pkg::side_type           pside;
      logic [RW+1:0]                 rem_sh;
      logic [RW+1:0]                 trial;
      logic                          fit;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prad  = radicand;
         assign prem  = '0;
         assign proot = '0;
         assign pnum  = in_num;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = vld_ff[k-1];
         assign prad  = rad_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign pnum  = num_ff[k-1];
         assign pside = side_ff[k-1];
      end

      // bring down the next radicand bit pair and try root*4+1
      assign rem_sh = {prem, prad[2*(N-1-k)+1 -: 2]};
      assign trial  = (RW+2)'({proot, 2'b01});
      assign fit    = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fit ? RW'(rem_sh - trial) : RW'(rem_sh);
            root_ff[k] <= {proot[N-2:0], fit};
            rad_ff[k]  <= prad;
            num_ff[k]  <= pnum;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign root      = root_ff[N-1];
   assign out_num   = num_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

@@ src/rmspr_div.sv @@
// Pipelined rounded divide of the step by the root, then weight update.
module rmspr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rmspr_pkg::ROOT_W-1:0]  root,
   input  logic [rmspr_pkg::NUM_W-1:0]   num,
   input  rmspr_pkg::side_type           in_side,
   output logic                          out_valid,
   output rmspr_pkg::res_type            result
);

   localparam int N  = rmspr_pkg::DIVN_W;
   localparam int RT = rmspr_pkg::ROOT_W;
   localparam int DW = rmspr_pkg::DATA_W;
   localparam int SW = N + 2;

   // prep stage: dividend with half divisor added for rounding
   logic                  pvld_ff;
   logic [N-1:0]          pn_ff;
   logic [RT-1:0]         pdv_ff;
   rmspr_pkg::side_type   pside_ff;

   logic                  vld_ff  [N];
   logic [N-1:0]          n_ff    [N];
   logic [RT-1:0]         dv_ff   [N];
   logic [RT-1:0]         r_ff    [N];
   logic [N-1:0]          q_ff    [N];
   rmspr_pkg::side_type   side_ff [N];

   // output stage
   logic                  ovld_ff;
   rmspr_pkg::res_type    res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else if (en) begin
         pvld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pn_ff    <= N'(num) + N'(root >> 1);
         pdv_ff   <= root;
         pside_ff <= in_side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                  pv;
      logic [N-1:0]          pn;
      logic [RT-1:0]         pdv;
      logic [RT-1:0]         pr;
      logic [N-1:0]          pq;
      rmspr_pkg::side_type   ps;
      logic [RT:0]           r_sh;
      logic                  fit;

      if (k == 0) begin : g_first
         assign pv  = pvld_ff;
         assign pn  = pn_ff;
         assign pdv = pdv_ff;
         assign pr  = '0;
         assign pq  = '0;
         assign ps  = pside_ff;
      end else begin : g_next
         assign pv  = vld_ff[k-1];
         assign pn  = n_ff[k-1];
         assign pdv = dv_ff[k-1];
         assign pr  = r_ff[k-1];
         assign pq  = q_ff[k-1];
         assign ps  = side_ff[k-1];
      end

      // restoring step, most significant dividend bit first
      assign r_sh = {pr, pn[N-1-k]};
      assign fit  = r_sh >= {1'b0, pdv};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]    <= fit ? RT'(r_sh - {1'b0, pdv}) : RT'(r_sh);
            q_ff[k]    <= {pq[N-2:0], fit};
            n_ff[k]    <= pn;
            dv_ff[k]   <= pdv;
            side_ff[k] <= ps;
         end
      end
   end

   // weight minus signed step, saturated
   logic signed [SW-1:0]  wide_w;
   logic signed [SW-1:0]  wide_q;
   logic signed [SW-1:0]  wsum;
   logic signed [DW-1:0]  wnew;
   rmspr_pkg::side_type   lside;

   assign lside  = side_ff[N-1];
   assign wide_w = SW'(lside.weight);
   assign wide_q = $signed({2'b00, q_ff[N-1]});
   assign wsum   = lside.gneg ? (wide_w + wide_q) : (wide_w - wide_q);

   always_comb begin
      if (wsum > SW'(32'sh7FFF_FFFF)) begin
         wnew = 32'sh7FFF_FFFF;
      end else if (wsum < SW'(32'sh8000_0000)) begin
         wnew = 32'sh8000_0000;
      end else begin
         wnew = DW'(wsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.new_weight <= wnew;
         res_ff.mean_sq    <= lside.mean_sq;
         res_ff.mean_grad  <= lside.mean_grad;
         res_ff.last       <= lside.last;
      end
   end

   assign out_valid = ovld_ff;
   assign result    = res_ff;

endmodule

@@ src/rmsprop_weight_update.sv @@
// RMSProp update top level: registers, pipeline and output buffer.
// An accepted item passes 7 front stages, 28 square root stages, 60 divide and update
// stages and the output register before rsp valid rises.
// Throughput: one item per cycle; the stages move together on a shared enable
// that drops only while the output skid register holds an item.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module rmsprop_weight_update (
   input  logic        clock,
   input  logic        reset,
   rmspr_req_if.sink   req_ch,
   rmspr_rsp_if.source rsp_ch,
   rmspr_csr_if.sink   csr_ch
);

   localparam int CW = rmspr_pkg::CFG_W;

   // configuration registers
   logic [CW-1:0] lr_ff, decay_ff, eps_ff;
   logic          centered_ff;
   rmspr_pkg::cfg_type cfg;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff       <= rmspr_pkg::LR_RESET;
         decay_ff    <= rmspr_pkg::DECAY_RESET;
         eps_ff      <= rmspr_pkg::EPS_RESET;
         centered_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            rmspr_pkg::CSR_LR:     lr_ff       <= CW'(csr_ch.data);
            rmspr_pkg::CSR_DECAY:  decay_ff    <= CW'(csr_ch.data);
            rmspr_pkg::CSR_EPS:    eps_ff      <= CW'(csr_ch.data);
            rmspr_pkg::CSR_CENTER: centered_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // effective values: decay capped at one, zero epsilon acts as one
   always_comb begin
      cfg.lr       = lr_ff;
      cfg.decay    = (decay_ff > rmspr_pkg::ONE) ? rmspr_pkg::ONE : decay_ff;
      cfg.omd      = rmspr_pkg::ONE - cfg.decay;
      cfg.eps      = (eps_ff == '0) ? CW'(1) : eps_ff;
      cfg.centered = centered_ff;
   end

   // pipeline
   logic                           en;
   logic                           skid_valid_ff, skid_valid_in;
   logic                           out_valid_ff, out_valid_in;
   rmspr_pkg::res_type             skid_data_ff, skid_data_in;
   rmspr_pkg::res_type             out_data_ff, out_data_in;

   logic                           f_valid;
   logic [rmspr_pkg::RAD_W-1:0]    f_rad;
   logic [rmspr_pkg::NUM_W-1:0]    f_num;
   rmspr_pkg::side_type            f_side;
   logic                           s_valid;
   logic [rmspr_pkg::ROOT_W-1:0]   s_root;
   logic [rmspr_pkg::NUM_W-1:0]    s_num;
   rmspr_pkg::side_type            s_side;
   logic                           p_valid;
   rmspr_pkg::res_type             p_data;
   logic                           take;

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   rmspr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cfg          (cfg),
      .in_valid     (req_ch.valid),
      .gradient     (req_ch.gradient),
      .weight       (req_ch.weight),
      .mean_sq_in   (req_ch.mean_sq_in),
      .mean_grad_in (req_ch.mean_grad_in),
      .last_in      (req_ch.last_in),
      .out_valid    (f_valid),
      .radicand     (f_rad),
      .num          (f_num),
      .side         (f_side)
   );

   rmspr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .radicand  (f_rad),
      .in_num    (f_num),
      .in_side   (f_side),
      .out_valid (s_valid),
      .root      (s_root),
      .out_num   (s_num),
      .out_side  (s_side)
   );

   rmspr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .root      (s_root),
      .num       (s_num),
      .in_side   (s_side),
      .out_valid (p_valid),
      .result    (p_data)
   );

   // output register with skid stage
   assign take = out_valid_ff && rsp_ch.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (p_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = p_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = p_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.new_weight    = out_data_ff.new_weight;
   assign rsp_ch.mean_sq_out   = out_data_ff.mean_sq;
   assign rsp_ch.mean_grad_out = out_data_ff.mean_grad;
   assign rsp_ch.last_out      = out_data_ff.last;

`ifndef SYNTH
   // skid only fills behind a waiting output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full with output empty");

   // a finished item meeting a blocked output lands in the skid stage
   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (!skid_valid_ff && out_valid_ff && !rsp_ch.ready && p_valid) |=> skid_valid_ff)
      else $error("finished item not caught by skid register");

   // decay never exceeds one and its complement adds up
   a_decay_split: assert property (@(posedge clock) disable iff (reset)
      (cfg.decay <= rmspr_pkg::ONE) && ((cfg.omd + cfg.decay) == rmspr_pkg::ONE))
      else $error("decay split inconsistent");

   // the root input never sees a zero epsilon
   a_eps_nonzero: assert property (@(posedge clock) disable iff (reset)
      cfg.eps != '0)
      else $error("effective epsilon is zero");
`endif

endmodule

@@ verif/rmspr_tb_pkg.sv @@
// Item and result types used by the RMSProp update testbench.
package rmspr_tb_pkg;

   // one parameter to update
   typedef struct {
      logic signed [rmspr_pkg::DATA_W-1:0] gradient;
      logic signed [rmspr_pkg::DATA_W-1:0] weight;
      logic [rmspr_pkg::SQ_W-1:0]          mean_sq;
      logic signed [rmspr_pkg::DATA_W-1:0] mean_grad;
      logic                                last;
   } param_item_type;

endpackage

@@ verif/testbench.sv @@
// Testbench for the RMSProp weight update block: own predictor, random and directed items.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   rmspr_req_if req_ch();
   rmspr_rsp_if rsp_ch();
   rmspr_csr_if csr_ch();

   rmsprop_weight_update dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   localparam int LATENCY = 96;
   localparam int FR      = rmspr_pkg::FRAC;
   localparam int DW      = rmspr_pkg::DATA_W;
   localparam int SW      = rmspr_pkg::SQ_W;
   localparam int CW      = rmspr_pkg::CFG_W;

   // predictor's copy of the registers
   logic [CW-1:0] lr_q, decay_q, eps_q;
   logic          centered_q;

   rmspr_pkg::res_type expected_updates[$];
   int          error_count;
   bit          idle_enable;
   bit          hold_rsp;
   longint      sent_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // compute the updated parameter from the current register copy
   function automatic rmspr_pkg::res_type rmsprop_update(rmspr_tb_pkg::param_item_type it);
      longint          g, w, mg, mg_new, den, macc, stepv, w_new;
      longint unsigned d, omd, eps, gmag, g2, acc, ms_new, mmag, mg2, root, num, q, m;
      rmspr_pkg::res_type r;
      g = longint'(it.gradient);
      w = longint'(it.weight);
      mg = longint'(it.mean_grad);
      d = (decay_q > 25'd16777216) ? 64'd16777216 : 64'(decay_q);
      omd = 64'd16777216 - d;
      eps = (eps_q == 0) ? 64'd1 : 64'(eps_q);
      gmag = (g < 0) ? 64'(-g) : 64'(g);
      g2 = (gmag * gmag + rmspr_pkg::HALF) >> FR;
      acc = omd * g2 + d * 64'(it.mean_sq);
      ms_new = (acc + rmspr_pkg::HALF) >> FR;
      if (ms_new > 64'd2147483647) ms_new = 64'd2147483647;
      mg_new = mg;
      den = longint'(ms_new);
      if (centered_q) begin
         macc = longint'(omd) * g + longint'(d) * mg;
         m = (macc < 0) ? 64'(-macc) : 64'(macc);
         m = (m + rmspr_pkg::HALF) >> FR;
         mg_new = sat32((macc < 0) ? -longint'(m) : longint'(m));
         mmag = (mg_new < 0) ? 64'(-mg_new) : 64'(mg_new);
         mg2 = (mmag * mmag + rmspr_pkg::HALF) >> FR;
         den = longint'(ms_new) - longint'(mg2);
         if (den < 0) den = 0;
      end
      root = int_sqrt((64'(den) + eps) << FR);
      if (root == 0) root = 1;
      num = 64'(lr_q) * gmag;
      q = (num + (root >> 1)) / root;
      stepv = (g < 0) ? -longint'(q) : longint'(q);
      w_new = sat32(w - stepv);
      r.new_weight = w_new[DW-1:0];
      r.mean_sq = ms_new[SW-1:0];
      r.mean_grad = mg_new[DW-1:0];
      r.last = it.last;
      return r;
   endfunction

   // random idle gap, sometimes; the input goes idle during it
   task automatic maybe_idle();
      int n;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // send one item and queue its expected result; valid stays up for the next item
   task automatic send_param(rmspr_tb_pkg::param_item_type it);
      maybe_idle();
      req_ch.valid <= 1'b1;
      req_ch.gradient <= it.gradient;
      req_ch.weight <= it.weight;
      req_ch.mean_sq_in <= it.mean_sq;
      req_ch.mean_grad_in <= it.mean_grad;
      req_ch.last_in <= it.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_updates.push_back(rmsprop_update(it));
      sent_count++;
   endtask

   // register write, only while idle
   task automatic write_reg(logic [rmspr_pkg::IDX_W-1:0] idx,
                            logic [rmspr_pkg::CSR_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         rmspr_pkg::CSR_LR:     lr_q = val[CW-1:0];
         rmspr_pkg::CSR_DECAY:  decay_q = val[CW-1:0];
         rmspr_pkg::CSR_EPS:    eps_q = val[CW-1:0];
         rmspr_pkg::CSR_CENTER: centered_q = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_updates.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic rmspr_tb_pkg::param_item_type rand_param();
      rmspr_tb_pkg::param_item_type it;
      int        sel;
      sel = $urandom_range(0, 9);
      it.gradient = $urandom;
      // mostly realistic magnitudes, some full range
      if (sel < 6) it.gradient = $signed(it.gradient) >>> $urandom_range(4, 12);
      it.weight = $urandom;
      it.mean_sq = SW'($urandom);
      if (sel < 5) it.mean_sq = it.mean_sq >> $urandom_range(6, 16);
      it.mean_grad = $urandom;
      if (sel < 6) it.mean_grad = $signed(it.mean_grad) >>> $urandom_range(4, 14);
      it.last = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic rmspr_tb_pkg::param_item_type mk(longint g, longint w, longint ms,
                                                       longint mg, bit l);
      rmspr_tb_pkg::param_item_type it;
      it.gradient = g[31:0];
      it.weight = w[31:0];
      it.mean_sq = ms[30:0];
      it.mean_grad = mg[31:0];
      it.last = l;
      return it;
   endfunction

   // extremes of fields and the named corner cases
   task automatic test_directed();
      send_param(mk(0, 0, 0, 0, 0));
      send_param(mk(32'h7fffffff, -2147483648, 31'h7fffffff, 32'h7fffffff, 1));
      send_param(mk(-2147483648, 32'h7fffffff, 0, -2147483648, 0));
      send_param(mk(16777216, 16777216, 16777216, 0, 1));
      send_param(mk(16777216, -2147483600, 0, 0, 0));   // weight saturates low
      send_param(mk(1, 32'h7ffffff0, 0, 0, 0));
      send_param(mk(-1, 32'h7ffffff0, 0, 0, 1));         // weight saturates high
      drain();
      write_reg(rmspr_pkg::CSR_CENTER, 32'd1);
      // negative denominator: large mean gradient, small mean square
      send_param(mk(16777216, 0, 0, 32'h40000000, 0));
      send_param(mk(-2147483648, 0, 0, -2147483648, 1));
      send_param(mk(32'h7fffffff, 5, 31'h7fffffff, 32'h7fffffff, 0));
      drain();
      write_reg(rmspr_pkg::CSR_DECAY, 32'h1ffffff);       // decay above one
      write_reg(rmspr_pkg::CSR_EPS, 32'd0);               // zero epsilon
      write_reg(rmspr_pkg::CSR_LR, 32'd16777216);
      send_param(mk(16777216, 0, 100, 50, 0));
      send_param(mk(-3, 7, 0, 0, 1));
      drain();
      write_reg(8'd9, 32'hffffffff);                      // unused index, ignored
      write_reg(rmspr_pkg::CSR_DECAY, 32'd0);
      write_reg(rmspr_pkg::CSR_EPS, 32'd16777216);
      write_reg(rmspr_pkg::CSR_CENTER, 32'd0);
      send_param(mk(16777216, 123, 456, 789, 0));
      send_param(mk(-2147483648, -1, 31'h7fffffff, 1, 1));
      drain();
   endtask

   // random items over several register settings
   task automatic test_random(int n, bit cen);
      rmspr_tb_pkg::param_item_type it;
      write_reg(rmspr_pkg::CSR_LR,
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16777216));
      write_reg(rmspr_pkg::CSR_DECAY, $urandom_range(0, 16777216));
      write_reg(rmspr_pkg::CSR_EPS, $urandom_range(1, 16777216) >> $urandom_range(0, 24));
      write_reg(rmspr_pkg::CSR_CENTER, 32'(cen));
      repeat (n) begin
         it = rand_param();
         send_param(it);
      end
      drain();
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            repeat (200) send_param(rand_param());
         end
      join
      drain();
   endtask

   // receiver ready with random stalls
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rmspr_pkg::res_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_updates.size() == 0) begin
            $error("result with no item pending");
            error_count++;
         end else begin
            e = expected_updates.pop_front();
            if (rsp_ch.new_weight !== e.new_weight) begin
               $error("new_weight exp %0d got %0d", e.new_weight, rsp_ch.new_weight);
               error_count++;
            end
            if (rsp_ch.mean_sq_out !== e.mean_sq) begin
               $error("mean_sq_out exp %0d got %0d", e.mean_sq, rsp_ch.mean_sq_out);
               error_count++;
            end
            if (rsp_ch.mean_grad_out !== e.mean_grad) begin
               $error("mean_grad_out exp %0d got %0d", e.mean_grad, rsp_ch.mean_grad_out);
               error_count++;
            end
            if (rsp_ch.last_out !== e.last) begin
               $error("last_out exp %0d got %0d", e.last, rsp_ch.last_out);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      error_count = 0;
      sent_count = 0;
      hold_rsp = 1'b0;
      idle_enable = 1'b1;
      lr_q = rmspr_pkg::LR_RESET;
      decay_q = rmspr_pkg::DECAY_RESET;
      eps_q = rmspr_pkg::EPS_RESET;
      centered_q = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.gradient = '0;
      req_ch.weight = '0;
      req_ch.mean_sq_in = '0;
      req_ch.mean_grad_in = '0;
      req_ch.last_in = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 1'b0);
      test_random(300, 1'b1);
      test_backpressure();
      test_random(300, 1'b1);
      test_random(300, 1'b0);
      idle_enable = 1'b0;
      test_random(300, 1'b1);
      if (expected_updates.size() != 0) begin
         $error("%0d results never arrived", expected_updates.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
